// File: hdl/scc_pkg.sv
`default_nettype none
package scc_pkg;

  localparam int NUM_SLOTS   = 64;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int SECTOR_BITS = 32;
  localparam int SLOT_FIELD_W = 6;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_EVICT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]             operation;
    logic [SECTOR_BITS-1:0] sector;
    logic                   cached_device;
  } req_t;

  typedef struct packed {
    logic                    bypass;
    logic                    hit;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    writeback_valid;
    logic [SECTOR_BITS-1:0]  writeback_sector;
    logic                    fill_needed;
    logic                    last;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic bypass;
    logic scan;
    logic flush;
    logic hit_upd;
    logic sweep;
    logic evict;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
    logic victim;
  } sts_t;

endpackage
`default_nettype wire

// File: hdl/sector_cache_clock_replacement.sv
// Bypass: result in the cycle after the transfer; busy stays low.
// Hit in slot i: result once the scan reaches slot i (tag memory scanned one slot a cycle).
// Miss: full tag scan, then clock-hand probes until an unreferenced slot is found, then eviction.
// Flush: busy during a full tag scan, one result per dirty slot in slot order.
// Results cannot be stalled by the receiver.
// Reset clears all valid, dirty and reference bits and the clock hand.
`default_nettype none
module sector_cache_clock_replacement (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire scc_pkg::req_t request,
  output logic               busy,
  output scc_pkg::rsp_t      result,
  output logic               result_strobe
);

  scc_pkg::cmd_t cmd;
  scc_pkg::sts_t sts;

  scc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  scc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .request       (request),
    .cmd           (cmd),
    .sts           (sts),
    .result        (result),
    .result_strobe (result_strobe)
  );

endmodule
`default_nettype wire

// File: hdl/scc_ctrl.sv
`default_nettype none
module scc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire scc_pkg::req_t request,
  input  wire scc_pkg::sts_t sts,
  output scc_pkg::cmd_t      cmd,
  output logic               busy
);

  scc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      scc_pkg::ST_IDLE: begin
        if (start) begin
          unique case (request.operation)
            scc_pkg::OP_READ, scc_pkg::OP_WRITE: begin
              if (request.cached_device) state_next = scc_pkg::ST_SCAN;
            end
            scc_pkg::OP_FLUSH: state_next = scc_pkg::ST_FLUSH;
            default: state_next = scc_pkg::ST_IDLE;
          endcase
        end
      end
      scc_pkg::ST_SCAN: begin
        if (sts.hit) state_next = scc_pkg::ST_IDLE;
        else if (sts.scan_done) state_next = scc_pkg::ST_SWEEP;
      end
      scc_pkg::ST_SWEEP: begin
        if (sts.victim) state_next = scc_pkg::ST_EVICT;
      end
      scc_pkg::ST_EVICT: state_next = scc_pkg::ST_IDLE;
      scc_pkg::ST_FLUSH: begin
        if (sts.scan_done) state_next = scc_pkg::ST_IDLE;
      end
      default: state_next = scc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      scc_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
        if (start && !request.cached_device &&
            (request.operation == scc_pkg::OP_READ ||
             request.operation == scc_pkg::OP_WRITE)) begin
          cmd.bypass = 1'b1;
        end
      end
      scc_pkg::ST_SCAN: begin
        cmd.scan    = 1'b1;
        cmd.hit_upd = sts.hit;
      end
      scc_pkg::ST_SWEEP: cmd.sweep = 1'b1;
      scc_pkg::ST_EVICT: cmd.evict = 1'b1;
      scc_pkg::ST_FLUSH: begin
        cmd.scan  = 1'b1;
        cmd.flush = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/scc_dp.sv
`default_nettype none
module scc_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire scc_pkg::req_t request,
  input  wire scc_pkg::cmd_t cmd,
  output scc_pkg::sts_t      sts,
  output scc_pkg::rsp_t      result,
  output logic               result_strobe
);

  localparam int N = scc_pkg::NUM_SLOTS;
  localparam int W = scc_pkg::SLOT_W;
  localparam int SW = scc_pkg::SECTOR_BITS;

  logic [SW-1:0] tag_mem [N];
  logic [SW-1:0] rdata;

  logic [N-1:0] valid;
  logic [N-1:0] dirty;
  logic [N-1:0] refd;

  logic [W-1:0]  hand, hand_inc;
  logic [W-1:0]  cnt, cnt_inc;
  logic [W-1:0]  stg_idx;
  logic          stg_vld;
  logic [W-1:0]  rd_addr;
  logic [1:0]    op_q;
  logic [SW-1:0] sec_q;
  logic          is_write;

  logic [N-1:0]  above;
  logic          flush_last;
  logic          flush_emit;
  scc_pkg::rsp_t rsp_next;
  logic          emit;

  assign hand_inc = (hand == W'(N - 1)) ? '0 : hand + 1'b1;
  assign cnt_inc  = (cnt == W'(N - 1)) ? '0 : cnt + 1'b1;
  assign rd_addr  = cmd.sweep ? hand_inc : cnt;
  assign is_write = (op_q == scc_pkg::OP_WRITE);

  assign sts.hit       = stg_vld && valid[stg_idx] && (rdata == sec_q);
  assign sts.scan_done = stg_vld && (stg_idx == W'(N - 1));
  assign sts.victim    = !refd[hand_inc];

  assign above      = ({N{1'b1}} << stg_idx) << 1;
  assign flush_last = ~|(dirty & above);
  assign flush_emit = cmd.flush && stg_vld && dirty[stg_idx];

  always_ff @(posedge clk) begin
    if (cmd.evict) tag_mem[hand] <= sec_q;
    rdata <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= request.operation;
      sec_q <= request.sector;
    end
    stg_idx <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      stg_vld <= 1'b0;
    end else if (cmd.load) begin
      cnt     <= '0;
      stg_vld <= 1'b0;
    end else begin
      if (cmd.scan) cnt <= cnt_inc;
      stg_vld <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      dirty <= '0;
      refd  <= '0;
      hand  <= '0;
    end else begin
      if (cmd.hit_upd) begin
        refd[stg_idx] <= 1'b1;
        if (is_write) dirty[stg_idx] <= 1'b1;
      end
      if (cmd.sweep) begin
        hand <= hand_inc;
        if (refd[hand_inc]) refd[hand_inc] <= 1'b0;
      end
      if (cmd.evict) begin
        valid[hand] <= 1'b1;
        dirty[hand] <= is_write;
        refd[hand]  <= 1'b1;
      end
    end
  end

  always_comb begin
    rsp_next = '0;
    emit     = 1'b0;
    priority if (cmd.bypass) begin
      emit            = 1'b1;
      rsp_next.bypass = 1'b1;
      rsp_next.last   = 1'b1;
    end else if (cmd.hit_upd) begin
      emit          = 1'b1;
      rsp_next.hit  = 1'b1;
      rsp_next.slot = scc_pkg::SLOT_FIELD_W'(stg_idx);
      rsp_next.last = 1'b1;
    end else if (cmd.evict) begin
      emit                     = 1'b1;
      rsp_next.slot            = scc_pkg::SLOT_FIELD_W'(hand);
      rsp_next.writeback_valid = dirty[hand];
      rsp_next.writeback_sector = dirty[hand] ? rdata : '0;
      rsp_next.fill_needed     = 1'b1;
      rsp_next.last            = 1'b1;
    end else if (flush_emit) begin
      emit                      = 1'b1;
      rsp_next.slot             = scc_pkg::SLOT_FIELD_W'(stg_idx);
      rsp_next.writeback_valid  = 1'b1;
      rsp_next.writeback_sector = rdata;
      rsp_next.last             = flush_last;
    end else begin
      emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) result <= rsp_next;
  end

endmodule
`default_nettype wire
